// ===== src/timer_bank_deadline_scan_macros.svh =====
// Assertion helpers for the timer bank; empty when synthesising.
`ifndef TIMER_BANK_DEADLINE_SCAN_MACROS_SVH
`define TIMER_BANK_DEADLINE_SCAN_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define TBDS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define TBDS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TBDS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define TBDS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== src/tbds_pkg.sv =====
package tbds_pkg;

    localparam int NUM_TIMERS_DEF = 8;

    localparam int OP_W     = 3;
    localparam int IDX_IN_W = 3;
    localparam int PMS_W    = 20;
    localparam int TIME_W   = 63;
    localparam int MHZ_W    = 12;
    localparam int PER_W    = 43;
    localparam int ST_W     = 2;
    localparam int MASK_W   = 8;
    localparam int PROD1_W  = PMS_W + MHZ_W;
    localparam int KILO_W   = 10;

    // Command opcodes
    localparam logic [OP_W-1:0] OP_SCAN    = 3'd0;
    localparam logic [OP_W-1:0] OP_START   = 3'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP    = 3'd3;
    localparam logic [OP_W-1:0] OP_FSTOP   = 3'd4;
    localparam logic [OP_W-1:0] OP_SETPER  = 3'd5;

    // Timer status codes
    localparam logic [ST_W-1:0] ST_STOPPED = 2'd0;
    localparam logic [ST_W-1:0] ST_RUNNING = 2'd1;
    localparam logic [ST_W-1:0] ST_EXPIRED = 2'd2;

    localparam logic [TIME_W-1:0] TIME_MAX     = {TIME_W{1'b1}};
    localparam logic [MHZ_W-1:0]  MHZ_RATE_RST = 12'd100;
    localparam logic [KILO_W-1:0] MS_TO_KILO   = 10'd1000;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_rd;
        logic per_rd;
        logic arm_add;
        logic arm_write;
        logic set_stop;
        logic mul1;
        logic mul2;
        logic per_wr;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            idx_valid;
        logic            scan_last;
        logic [ST_W-1:0] addr_status;
    } stat_t;

endpackage

// ===== src/tbds_ctrl.sv =====
module tbds_ctrl
    import tbds_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_FLUSH,
        S_ARM_ADD,
        S_ARM_WR,
        S_STOP,
        S_MUL1,
        S_MUL2,
        S_PER_WR,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign s_ready  = aresetn && (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Sequence commands and pick next state
    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (stat.op == OP_SCAN) begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end else if (!stat.idx_valid) begin
                    state_next = S_DONE;
                end else begin
                    case (stat.op)
                        OP_START, OP_RESTART: begin
                            cmd.per_rd = 1'b1;
                            state_next = S_ARM_ADD;
                        end
                        OP_STOP, OP_FSTOP: state_next = S_STOP;
                        OP_SETPER:         state_next = S_MUL1;
                        default:           state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (stat.scan_last) begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: state_next = S_DONE;
            S_ARM_ADD: begin
                cmd.arm_add = 1'b1;
                state_next  = S_ARM_WR;
            end
            S_ARM_WR: begin
                // start needs a stopped timer, restart also takes an expired one
                cmd.arm_write = (stat.addr_status == ST_STOPPED) ||
                                ((stat.op == OP_RESTART) && (stat.addr_status == ST_EXPIRED));
                state_next    = S_DONE;
            end
            S_STOP: begin
                cmd.set_stop = (stat.op == OP_FSTOP) || (stat.addr_status == ST_RUNNING);
                state_next   = S_DONE;
            end
            S_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = S_PER_WR;
            end
            S_PER_WR: begin
                cmd.per_wr = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                // hold here while the previous result is still unclaimed
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state and the result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== src/tbds_datapath.sv =====
module tbds_datapath
    import tbds_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [MHZ_W-1:0]    cfg_wr_data,
    input  logic [OP_W-1:0]     s_opcode,
    input  logic [IDX_IN_W-1:0] s_timer_index,
    input  logic [PMS_W-1:0]    s_period_ms,
    input  logic [TIME_W-1:0]   s_now,
    output logic [MASK_W-1:0]   m_expired_mask,
    output logic [TIME_W-1:0]   m_earliest_deadline,
    output logic [ST_W-1:0]     m_addressed_status,
    input  cmd_t                cmd,
    output stat_t               stat
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int AW    = (IDX_W > IDX_IN_W) ? IDX_W : IDX_IN_W;

    // Captured transaction
    logic [OP_W-1:0]     op_reg;
    logic [IDX_IN_W-1:0] idx_reg;
    logic [PMS_W-1:0]    pms_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [MHZ_W-1:0]    mhz_rate_reg;

    // Timer state
    logic [ST_W-1:0]   status_reg [0:NUM_TIMERS-1];
    logic [NUM_TIMERS-1:0] per_valid_reg;
    logic [PER_W-1:0]  per_mem [0:NUM_TIMERS-1];
    logic [TIME_W-1:0] dl_mem  [0:NUM_TIMERS-1];
    logic [TIME_W-1:0] nd_reg;

    // Working registers
    logic [IDX_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   eval_addr_reg;
    logic               eval_v_reg;
    logic [TIME_W-1:0]  dl_q_reg;
    logic [PER_W-1:0]   per_q_reg;
    logic               per_vq_reg;
    logic [TIME_W-1:0]  arm_d_reg;
    logic [PROD1_W-1:0] prod1_reg;
    logic [PER_W-1:0]   prod2_reg;
    logic [MASK_W-1:0]  mask_reg;

    // Result registers
    logic [MASK_W-1:0] out_mask_reg;
    logic [TIME_W-1:0] out_nd_reg;
    logic [ST_W-1:0]   out_st_reg;

    logic [AW-1:0]     idx_ext;
    logic [IDX_W-1:0]  idx_a;
    logic [AW-1:0]     eval_ext;
    logic              idx_valid;
    logic [IDX_W-1:0]  st_addr;
    logic [ST_W-1:0]   st_rd;
    logic              eval_run;
    logic              eval_exp;
    logic [PER_W-1:0]  per_eff;
    logic [TIME_W:0]   arm_sum;

    assign idx_ext   = AW'(idx_reg);
    assign idx_a     = idx_ext[IDX_W-1:0];
    assign eval_ext  = AW'(eval_addr_reg);
    assign idx_valid = (32'(idx_reg) < NUM_TIMERS);

    // Single status read port: scan entry under test, else addressed timer
    assign st_addr  = eval_v_reg ? eval_addr_reg : idx_a;
    assign st_rd    = status_reg[st_addr];
    assign eval_run = eval_v_reg && (st_rd == ST_RUNNING);
    assign eval_exp = eval_run && (dl_q_reg < now_reg);

    assign per_eff = per_vq_reg ? per_q_reg : '0;
    assign arm_sum = {1'b0, now_reg} + (TIME_W + 1)'(per_eff);

    assign stat.op          = op_reg;
    assign stat.idx_valid   = idx_valid;
    assign stat.scan_last   = (cnt_reg == IDX_W'(NUM_TIMERS - 1));
    assign stat.addr_status = st_rd;

    assign m_expired_mask      = out_mask_reg;
    assign m_earliest_deadline = out_nd_reg;
    assign m_addressed_status  = out_st_reg;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mhz_rate_reg <= MHZ_RATE_RST;
        end else if (cfg_wr_en) begin
            mhz_rate_reg <= cfg_wr_data;
        end
    end

    // Capture the transaction
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_opcode;
            idx_reg <= s_timer_index;
            pms_reg <= s_period_ms;
            now_reg <= s_now;
        end
    end

    // Timer status: expire on scan, arm, stop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                status_reg[i] <= ST_STOPPED;
            end
        end else if (eval_exp) begin
            status_reg[eval_addr_reg] <= ST_EXPIRED;
        end else if (cmd.arm_write) begin
            status_reg[idx_a] <= ST_RUNNING;
        end else if (cmd.set_stop) begin
            status_reg[idx_a] <= ST_STOPPED;
        end
    end

    // Scan sequencing and read pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eval_v_reg <= 1'b0;
        end else begin
            eval_v_reg <= cmd.scan_rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_init) begin
            cnt_reg <= '0;
        end else if (cmd.scan_rd) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.scan_rd) begin
            eval_addr_reg <= cnt_reg;
        end
    end

    // Deadline memory
    always_ff @(posedge aclk) begin
        if (cmd.arm_write) begin
            dl_mem[idx_a] <= arm_d_reg;
        end
        if (cmd.scan_rd) begin
            dl_q_reg <= dl_mem[cnt_reg];
        end
    end

    // Period memory, with valid bits standing in for its zero reset
    always_ff @(posedge aclk) begin
        if (cmd.per_wr) begin
            per_mem[idx_a] <= prod2_reg;
        end
        if (cmd.per_rd) begin
            per_q_reg <= per_mem[idx_a];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            per_valid_reg <= '0;
        end else if (cmd.per_wr) begin
            per_valid_reg[idx_a] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.per_rd) begin
            per_vq_reg <= per_valid_reg[idx_a];
        end
    end

    // Arm: deadline = now + period, saturated
    always_ff @(posedge aclk) begin
        if (cmd.arm_add) begin
            arm_d_reg <= arm_sum[TIME_W] ? TIME_MAX : arm_sum[TIME_W-1:0];
        end
    end

    // Period conversion over two multiply steps
    always_ff @(posedge aclk) begin
        if (cmd.mul1) begin
            prod1_reg <= PROD1_W'(pms_reg) * PROD1_W'(mhz_rate_reg);
        end
        if (cmd.mul2) begin
            prod2_reg <= PER_W'(prod1_reg) * PER_W'(MS_TO_KILO);
        end
    end

    // Earliest deadline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nd_reg <= TIME_MAX;
        end else if (cmd.scan_init) begin
            nd_reg <= TIME_MAX;
        end else if (eval_run && !eval_exp) begin
            if (dl_q_reg < nd_reg) begin
                nd_reg <= dl_q_reg;
            end
        end else if (cmd.arm_write) begin
            if (arm_d_reg < nd_reg) begin
                nd_reg <= arm_d_reg;
            end
        end
    end

    // Expired mask for the current scan
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mask_reg <= '0;
        end else if (eval_exp && (32'(eval_addr_reg) < MASK_W)) begin
            mask_reg[eval_ext[2:0]] <= 1'b1;
        end
    end

    // Result registers
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_mask_reg <= mask_reg;
            out_nd_reg   <= nd_reg;
            out_st_reg   <= idx_valid ? st_rd : ST_STOPPED;
        end
    end

endmodule

// ===== src/timer_bank_deadline_scan.sv =====
// Timer bank with deadline scan.
// Input channel (s_valid/s_ready) carries one command per transaction:
// opcode, timer index, period in ms and the current time in cycles.
// Result channel (m_valid/m_ready) returns one transaction per command:
// the expired mask, the earliest pending deadline and the addressed
// timer's status. cfg_wr_en/cfg_wr_data set the clock rate in MHz.
// One transaction is processed at a time; s_ready is high while idle.
// A scan reads the deadline memory one timer per cycle; start and
// restart read the period, add it to now and then arm; set period
// passes through two multiply steps. A new command is accepted the
// cycle after the result is registered.
// The result register lets the next command be accepted while the last
// result waits; if m_ready stays low the block holds the finished
// result of the following command until the register frees.
// Reset (aresetn low, synchronous) stops all timers, zeroes periods,
// sets the earliest deadline to its maximum and the clock rate to 100 MHz.
`include "timer_bank_deadline_scan_macros.svh"

module timer_bank_deadline_scan
    import tbds_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [MHZ_W-1:0]    cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_opcode,
    input  logic [IDX_IN_W-1:0] s_timer_index,
    input  logic [PMS_W-1:0]    s_period_ms,
    input  logic [TIME_W-1:0]   s_now,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [MASK_W-1:0]   m_expired_mask,
    output logic [TIME_W-1:0]   m_earliest_deadline,
    output logic [ST_W-1:0]     m_addressed_status
);

    cmd_t  cmd;
    stat_t stat;

    tbds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tbds_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_opcode            (s_opcode),
        .s_timer_index       (s_timer_index),
        .s_period_ms         (s_period_ms),
        .s_now               (s_now),
        .m_expired_mask      (m_expired_mask),
        .m_earliest_deadline (m_earliest_deadline),
        .m_addressed_status  (m_addressed_status),
        .cmd                 (cmd),
        .stat                (stat)
    );

    // Checks on controller sequencing
    `TBDS_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "accepted while busy")
    `TBDS_ASSERT_IMP(a_arm_not_running, aclk, aresetn, cmd.arm_write, stat.addr_status != ST_RUNNING, "armed a running timer")
    `TBDS_ASSERT_IMP(a_out_load_free, aclk, aresetn, cmd.out_load, !m_valid || m_ready, "result overwritten")

endmodule

// ===== bench/timer_bank_deadline_scan_test.sv =====
`timescale 1ns / 1ps

module timer_bank_deadline_scan_test;
    import tbds_pkg::*;

    // Opcodes that the bank leaves without effect
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int PHASES           = 6;
    localparam int RANDOM_PER_PHASE = 330;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int PRINT_LIMIT      = 50;

    typedef struct {
        logic [OP_W-1:0]     opcode;
        logic [IDX_IN_W-1:0] timer_index;
        logic [PMS_W-1:0]    period_ms;
        logic [TIME_W-1:0]   now;
    } timer_cmd_t;

    typedef struct {
        logic [MASK_W-1:0] mask;
        logic [TIME_W-1:0] deadline;
        logic [ST_W-1:0]   status;
    } timer_result_t;

    logic                aclk;
    logic                aresetn         = 1'b0;
    logic                cfg_wr_en       = 1'b0;
    logic [MHZ_W-1:0]    cfg_wr_data     = MHZ_RATE_RST;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_opcode        = '0;
    logic [IDX_IN_W-1:0] s_timer_index   = '0;
    logic [PMS_W-1:0]    s_period_ms     = '0;
    logic [TIME_W-1:0]   s_now           = '0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic [MASK_W-1:0]   m_expired_mask;
    logic [TIME_W-1:0]   m_earliest_deadline;
    logic [ST_W-1:0]     m_addressed_status;

    // Shadow copy of the timer bank
    logic [ST_W-1:0]   bank_status   [NUM_TIMERS_DEF];
    logic [PER_W-1:0]  bank_period   [NUM_TIMERS_DEF];
    logic [TIME_W-1:0] bank_deadline [NUM_TIMERS_DEF];
    logic [TIME_W-1:0] soonest_deadline;
    logic [MHZ_W-1:0]  model_mhz;

    timer_cmd_t    pending_cmds[$];
    timer_result_t expected_results[$];
    timer_cmd_t    in_flight;

    int  items_queued    = 0;
    int  items_accepted  = 0;
    int  results_checked = 0;
    int  expiries_seen   = 0;
    int  saturated_arms  = 0;
    int  mhz_writes      = 0;
    int  mismatches      = 0;
    int  cycle_count     = 0;
    int  drv_gap         = 0;
    int  rdy_gap         = 0;
    bit  calm            = 1'b0;

    timer_bank_deadline_scan DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_opcode            (s_opcode),
        .s_timer_index       (s_timer_index),
        .s_period_ms         (s_period_ms),
        .s_now               (s_now),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_expired_mask      (m_expired_mask),
        .m_earliest_deadline (m_earliest_deadline),
        .m_addressed_status  (m_addressed_status)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Gap length for either side: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [IDX_IN_W-1:0] idx,
                             input logic [PMS_W-1:0] pms, input logic [TIME_W-1:0] now);
        timer_cmd_t c;
        c.opcode      = op;
        c.timer_index = idx;
        c.period_ms   = pms;
        c.now         = now;
        pending_cmds.push_back(c);
        items_queued++;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_LIMIT) begin
            $display("tb: mismatch on %s at result %0d: got %h, want %h",
                     what, results_checked, got, want);
        end
        mismatches++;
    endtask

    // Apply one command to the shadow bank and queue the result it yields
    task automatic predict_timer_cmd(input timer_cmd_t c);
        timer_result_t r;
        int            i;
        logic [63:0]   sum;
        logic [63:0]   prod;
        r.mask = '0;
        if (c.opcode == OP_SCAN) begin
            soonest_deadline = TIME_MAX;
            for (i = 0; i < NUM_TIMERS_DEF; i++) begin
                if (bank_status[i] == ST_RUNNING) begin
                    if (bank_deadline[i] < c.now) begin
                        bank_status[i] = ST_EXPIRED;
                        if (i < MASK_W) begin
                            r.mask[i] = 1'b1;
                        end
                    end else if (bank_deadline[i] < soonest_deadline) begin
                        soonest_deadline = bank_deadline[i];
                    end
                end
            end
        end else if (c.timer_index < NUM_TIMERS_DEF) begin
            case (c.opcode)
                OP_START, OP_RESTART: begin
                    // Start arms a stopped timer only; restart an expired one as well
                    if (bank_status[c.timer_index] == ST_STOPPED ||
                        (c.opcode == OP_RESTART && bank_status[c.timer_index] == ST_EXPIRED)) begin
                        sum = {1'b0, c.now} + 64'(bank_period[c.timer_index]);
                        if (sum >= {1'b0, TIME_MAX}) begin
                            sum = {1'b0, TIME_MAX};
                            saturated_arms++;
                        end
                        bank_status[c.timer_index]   = ST_RUNNING;
                        bank_deadline[c.timer_index] = sum[TIME_W-1:0];
                        if (sum[TIME_W-1:0] < soonest_deadline) begin
                            soonest_deadline = sum[TIME_W-1:0];
                        end
                    end
                end
                OP_STOP: begin
                    if (bank_status[c.timer_index] == ST_RUNNING) begin
                        bank_status[c.timer_index] = ST_STOPPED;
                    end
                end
                OP_FSTOP: begin
                    bank_status[c.timer_index] = ST_STOPPED;
                end
                OP_SETPER: begin
                    prod = 64'(c.period_ms) * 64'(model_mhz) * 64'(MS_TO_KILO);
                    bank_period[c.timer_index] = prod[PER_W-1:0];
                end
                default: begin
                end
            endcase
        end
        r.deadline = soonest_deadline;
        r.status   = (c.timer_index < NUM_TIMERS_DEF) ? bank_status[c.timer_index] : ST_STOPPED;
        expiries_seen += $countones(r.mask);
        expected_results.push_back(r);
    endtask

    // Hold until every queued command has been taken and answered
    task automatic wait_drained();
        while (!(items_accepted == items_queued && expected_results.size() == 0)) begin
            @(negedge aclk);
        end
    endtask

    // Driver: present queued commands, hold each until its transaction completes
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            drv_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_timer_cmd(in_flight);
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (drv_gap > 0 || pending_cmds.size() == 0) begin
                    s_valid <= 1'b0;
                    if (drv_gap > 0) begin
                        drv_gap--;
                    end
                end else begin
                    in_flight = pending_cmds.pop_front();
                    s_valid       <= 1'b1;
                    s_opcode      <= in_flight.opcode;
                    s_timer_index <= in_flight.timer_index;
                    s_period_ms   <= in_flight.period_ms;
                    s_now         <= in_flight.now;
                    drv_gap = pick_gap();
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        timer_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rdy_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 64'(m_earliest_deadline), '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_expired_mask !== want.mask) begin
                        report_mismatch("expired_mask", 64'(m_expired_mask), 64'(want.mask));
                    end
                    if (m_earliest_deadline !== want.deadline) begin
                        report_mismatch("earliest_deadline", 64'(m_earliest_deadline),
                                        64'(want.deadline));
                    end
                    if (m_addressed_status !== want.status) begin
                        report_mismatch("addressed_status", 64'(m_addressed_status),
                                        64'(want.status));
                    end
                    results_checked++;
                end
            end
            // Stall the result side now and then
            if (rdy_gap > 0) begin
                m_ready <= 1'b0;
                rdy_gap--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 99) < 20) begin
                    rdy_gap = pick_gap();
                end
            end
        end
    end

    // Abandon a run that hangs
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int                ph;
        int                k;
        int                r;
        int                unit;
        int                mhz_plan [PHASES];
        logic [OP_W-1:0]   op;
        logic [PMS_W-1:0]  pms;
        logic [TIME_W-1:0] gen_now;
        logic [63:0]       wide;

        for (k = 0; k < NUM_TIMERS_DEF; k++) begin
            bank_status[k]   = ST_STOPPED;
            bank_period[k]   = '0;
            bank_deadline[k] = '0;
        end
        soonest_deadline = TIME_MAX;
        model_mhz        = MHZ_RATE_RST;

        mhz_plan[0] = int'(MHZ_RATE_RST);
        mhz_plan[1] = 1;
        mhz_plan[2] = 4095;
        mhz_plan[3] = $urandom_range(2, 4094);
        mhz_plan[4] = $urandom_range(1, 4095);
        mhz_plan[5] = int'(MHZ_RATE_RST);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening at the reset clock rate
        queue_cmd(OP_SCAN, 0, 0, 0);                    // empty bank
        queue_cmd(OP_SETPER, 0, 0, 0);                  // zero period
        queue_cmd(OP_START, 0, 20'hFFFFF, 10);
        queue_cmd(OP_SCAN, 0, 0, 10);                   // deadline equals now: keep running
        queue_cmd(OP_SCAN, 0, 0, 11);                   // deadline passed: expire
        queue_cmd(OP_START, 0, 0, 20);                  // expired timer ignores start
        queue_cmd(OP_RESTART, 0, 0, 20);
        queue_cmd(OP_SETPER, 1, 20'hFFFFF, 0);          // largest period
        queue_cmd(OP_START, 1, 0, TIME_MAX - 5);        // deadline saturates
        queue_cmd(OP_START, 1, 0, 0);                   // running: ignored
        queue_cmd(OP_RESTART, 1, 0, 0);                 // running: ignored
        queue_cmd(OP_STOP, 0, 0, 30);                   // earliest deadline goes stale
        queue_cmd(OP_STOP, 0, 0, 30);                   // already stopped
        queue_cmd(OP_RESTART, 0, 0, 5);
        queue_cmd(OP_SCAN, 7, 0, TIME_MAX);             // saturated timer never expires
        queue_cmd(OP_STOP, 0, 0, 0);                    // expired: stop leaves it
        queue_cmd(OP_FSTOP, 0, 0, 0);
        queue_cmd(OP_FSTOP, 1, 0, 0);
        queue_cmd(OP_FSTOP, 2, 0, 0);
        queue_cmd(OP_SPARE_6, 7, 20'hFFFFF, TIME_MAX);
        queue_cmd(OP_SPARE_7, 1, 20'h5A5A5, 0);
        queue_cmd(OP_SCAN, 1, 0, TIME_MAX);

        gen_now = '0;
        for (ph = 0; ph < PHASES; ph++) begin
            // Change the clock rate only while the bank is idle
            if (ph > 0) begin
                @(posedge aclk);
                cfg_wr_en   <= 1'b1;
                cfg_wr_data <= MHZ_W'(mhz_plan[ph]);
                @(posedge aclk);
                cfg_wr_en   <= 1'b0;
                model_mhz = MHZ_W'(mhz_plan[ph]);
                mhz_writes++;
            end
            calm = (ph == 2);
            unit = int'(model_mhz) * 1000;

            // Largest period at this rate, armed then scanned
            k = $urandom_range(0, NUM_TIMERS_DEF - 1);
            queue_cmd(OP_SETPER, IDX_IN_W'(k), 20'hFFFFF, gen_now);
            queue_cmd(OP_FSTOP, IDX_IN_W'(k), 0, gen_now);
            queue_cmd(OP_START, IDX_IN_W'(k), 0, gen_now);
            queue_cmd(OP_SCAN, IDX_IN_W'(k), 0, gen_now + 1);

            // Random traffic: mostly short periods with time moving forward
            for (k = 0; k < RANDOM_PER_PHASE; k++) begin
                r = $urandom_range(0, 99);
                if (r < 30) begin
                    op = OP_SCAN;
                end else if (r < 45) begin
                    op = OP_START;
                end else if (r < 60) begin
                    op = OP_RESTART;
                end else if (r < 68) begin
                    op = OP_STOP;
                end else if (r < 75) begin
                    op = OP_FSTOP;
                end else if (r < 95) begin
                    op = OP_SETPER;
                end else begin
                    op = ($urandom_range(0, 1) != 0) ? OP_SPARE_6 : OP_SPARE_7;
                end
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    pms = PMS_W'($urandom_range(0, 3));
                end else if (r < 90) begin
                    pms = PMS_W'($urandom_range(0, 50));
                end else begin
                    pms = PMS_W'($urandom);
                end
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    wide    = {$urandom, $urandom};
                    gen_now = wide[TIME_W-1:0];
                end else if (r < 5) begin
                    gen_now = TIME_MAX - TIME_W'($urandom_range(0, 50_000_000));
                end else begin
                    gen_now = gen_now + TIME_W'($urandom_range(0, unit * 3));
                end
                queue_cmd(op, IDX_IN_W'($urandom_range(0, 7)), pms, gen_now);
            end

            // Pause the sender until every result of this phase is back
            wait_drained();
        end

        repeat (20) @(posedge aclk);

        $display("tb: %0d commands, %0d results checked, %0d expiries, %0d saturated deadlines",
                 items_accepted, results_checked, expiries_seen, saturated_arms);
        $display("tb: %0d clock rate settings written, %0d mismatches", mhz_writes, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
